// File: sv/imukf_pkg.sv
// Package for the IMU angle Kalman filter: payload structs, register codes,
// saturation helper and fixed constants. No dependencies.
package imukf_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int QDEPTH        = 2;

	// configuration register indexes
	localparam logic [1:0] CFG_TIME_STEP   = 2'd0;
	localparam logic [1:0] CFG_PROC_NOISE  = 2'd1;
	localparam logic [1:0] CFG_MEAS_NOISE  = 2'd2;

	localparam int TS_W  = 17;
	localparam int NZ_W  = 31;
	localparam int CFG_W = 31;

	// reciprocals for exact floor division of values below 2^32
	localparam logic signed [33:0] RECIP3 = 34'sh0AAAAAAAB;
	localparam logic signed [33:0] RECIP5 = 34'sh0CCCCCCCD;
	localparam int SH3 = 33;
	localparam int SH5 = 34;

	typedef struct packed {
		logic signed [31:0] accel_lateral;
		logic signed [31:0] accel_vertical;
		logic signed [31:0] gyro_rate;
	} in_t;

	typedef struct packed {
		logic signed [31:0] fused_angle;
		logic signed [31:0] bias_estimate;
		logic signed [31:0] tilt_angle;
		logic               ratio_fault;
	} out_t;

	// classified sample as queued between front and back
	typedef struct packed {
		logic signed [31:0] ay;
		logic signed [31:0] az;
		logic signed [31:0] g;
		logic               fault;
		logic               xneg;
	} item_t;

	// clamp to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [69:0] v);
		logic signed [31:0] r;
		if (v > 70'sh7FFFFFFF)
			r = 32'sh7FFFFFFF;
		else if (v < -70'sh80000000)
			r = 32'sh80000000;
		else
			r = v[31:0];
		return r;
	endfunction

endpackage

// File: sv/imukf_front.sv
// Front end: takes samples, flags ratio faults, and queues them for the back end.
// Depends on imukf_pkg.
module imukf_front import imukf_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  in_t   sample,
	output logic  q_valid,
	output item_t q_item,
	input  logic  q_pop
);
	localparam int AW = $clog2(QDEPTH);

	item_t             mem_q [QDEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [AW:0]       cnt_q;
	item_t             cls;
	logic [32:0]       may, maz;
	logic              do_push, do_pop;

	// classify: zero divisor or ratio beyond two saturates
	always_comb begin
		may = sample.accel_lateral[31] ? 33'(-{sample.accel_lateral[31], sample.accel_lateral})
		                               : {1'b0, sample.accel_lateral};
		maz = sample.accel_vertical[31] ? 33'(-{sample.accel_vertical[31], sample.accel_vertical})
		                                : {1'b0, sample.accel_vertical};
		cls.ay = sample.accel_lateral;
		cls.az = sample.accel_vertical;
		cls.g  = sample.gyro_rate;
		if (sample.accel_vertical == 32'sd0) begin
			cls.fault = 1'b1;
			cls.xneg  = sample.accel_lateral[31];
		end else begin
			cls.fault = {1'b0, may} > {maz, 1'b0};
			cls.xneg  = sample.accel_lateral[31] ^ sample.accel_vertical[31];
		end
	end

	assign full    = cnt_q == (AW+1)'(QDEPTH);
	assign q_valid = cnt_q != '0;
	assign q_item  = mem_q[rd_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	// request queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				mem_q[wr_q] <= cls;
				wr_q <= (wr_q == AW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop)
				rd_q <= (rd_q == AW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

// File: sv/imukf_div.sv
// Shared radix-2 divider: round(|n| * 2^F / |d|), signed, saturated to 32 bits.
// Depends on imukf_pkg.
module imukf_div import imukf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] num,
	input  logic signed [33:0] den,
	output logic               done,
	output logic signed [31:0] quot
);
	localparam int NW = 32 + FRAC_BITS + 1;

	logic [31:0]   un;
	logic [32:0]   ud;
	logic [NW-1:0] nsum;
	logic [FRAC_BITS:0] hi;
	logic [32:0]   ud_q;
	logic [31:0]   rem_q, low_q, q_q;
	logic [4:0]    cnt_q;
	logic          busy_q, done_q, ovf_q, neg_q, big;
	logic [32:0]   rem2;
	logic          ge;
	logic [33:0]   den_m;

	// operand setup: magnitudes, rounding offset, overflow check
	always_comb begin
		un    = num[31] ? 32'(-num) : 32'(num);
		den_m = den[33] ? 34'(-den) : 34'(den);
		ud    = den_m[32:0];
		nsum  = NW'({un, {FRAC_BITS{1'b0}}}) + NW'(ud >> 1);
		hi    = nsum[NW-1:32];
	end

	assign rem2 = {rem_q, low_q[31]};
	assign ge   = rem2 >= ud_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= 5'd31;
				ud_q   <= ud;
				ovf_q  <= 34'(hi) >= {1'b0, ud};
				rem_q  <= 32'(hi);
				low_q  <= nsum[31:0];
				neg_q  <= num[31] ^ den[33];
			end else if (busy_q) begin
				rem_q <= ge ? 32'(rem2 - ud_q) : rem2[31:0];
				low_q <= {low_q[30:0], 1'b0};
				q_q   <= {q_q[30:0], ge};
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// clamp and sign
	always_comb begin
		big = ovf_q || q_q[31];
		if (neg_q)
			quot = big ? 32'sh80000000 : -$signed(q_q);
		else
			quot = big ? 32'sh7FFFFFFF : $signed(q_q);
	end

	assign done = done_q;

endmodule

// File: sv/imukf_back.sv
// Back end: sequencer with one shared multiplier and the shared divider that runs
// the predict, accelerometer angle and correct steps. Depends on imukf_pkg, imukf_div.
module imukf_back import imukf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  item_t              q_item,
	output logic               q_pop,
	input  logic [TS_W-1:0]    time_step,
	input  logic [NZ_W-1:0]    process_noise,
	input  logic [NZ_W-1:0]    measurement_noise,
	output logic               empty,
	input  logic               pop,
	output out_t               result
);
	localparam logic signed [31:0] ONE_FX   = 32'sd1 <<< FRAC_BITS;
	localparam logic signed [31:0] ANG_RST  = 32'(((1 << FRAC_BITS) + 5) / 10);
	localparam logic signed [31:0] BIAS_RST = 32'(((1 << FRAC_BITS) + 500) / 1000);
	localparam logic signed [68:0] HALF     = 69'sd1 <<< (FRAC_BITS - 1);

	typedef enum logic [4:0] {
		ST_IDLE, ST_A, ST_B, ST_C, ST_D, ST_E, ST_F, ST_DW,
		ST_X2, ST_X2C, ST_X3, ST_X3C, ST_X5, ST_X5C, ST_D5, ST_ACC,
		ST_EI, ST_K0W, ST_K1W, ST_U0, ST_U1, ST_U2, ST_U3, ST_U4, ST_U5, ST_U6,
		ST_OUT
	} state_t;

	state_t st_q;
	item_t  it_q;
	logic signed [31:0] ang_q, bias_q, caa_q, cab_q, cba_q, cbb_q;
	logic signed [31:0] t00_q, t01_q, p00_q, p10_q, p11_q;
	logic signed [31:0] x_q, x2_q, x3_q, acc_q, e_q, k0_q, k1_q, d3_q;
	logic [32:0]        m3_q, m5_q;
	logic               n3_q, n5_q;
	logic signed [33:0] s_q;
	logic signed [67:0] prod_q;
	logic               out_v_q;
	out_t               out_q;

	logic signed [33:0] ma, mb;
	logic signed [68:0] rsum, rnd;
	logic signed [31:0] fxr;
	logic signed [33:0] s_c;
	logic signed [31:0] d3s, d5s;
	logic [32:0]        d5u;

	logic               dv_start, dv_done;
	logic signed [31:0] dv_num, dv_quot;
	logic signed [33:0] dv_den;

	// rounded product of the previous cycle's multiply
	assign rsum = {prod_q[67], prod_q} + HALF;
	assign rnd  = rsum >>> FRAC_BITS;
	assign fxr  = sat32(70'(rnd));

	// operand select for the shared multiplier
	always_comb begin
		ma = 34'(signed'({1'b0, time_step}));
		mb = '0;
		case (st_q)
			ST_A:   mb = 34'(it_q.g) - 34'(bias_q);
			ST_B:   mb = 34'(cba_q);
			ST_C:   mb = 34'(cbb_q);
			ST_E:   mb = 34'(t01_q);
			ST_X2:  begin ma = 34'(x_q);  mb = 34'(x_q);  end
			ST_X3:  begin ma = 34'(x2_q); mb = 34'(x_q);  end
			ST_X5:  begin ma = 34'(x3_q); mb = 34'(x2_q); end
			ST_X5C: begin ma = signed'({1'b0, m3_q}); mb = RECIP3; end
			ST_D5:  begin ma = signed'({1'b0, m5_q}); mb = RECIP5; end
			ST_U0:  begin ma = 34'(k0_q); mb = 34'(e_q);   end
			ST_U1:  begin ma = 34'(k1_q); mb = 34'(e_q);   end
			ST_U2:  begin ma = 34'(k0_q); mb = 34'(p00_q); end
			ST_U3:  begin ma = 34'(k0_q); mb = 34'(t01_q); end
			ST_U4:  begin ma = 34'(k1_q); mb = 34'(p00_q); end
			ST_U5:  begin ma = 34'(k1_q); mb = 34'(t01_q); end
			default: mb = '0;
		endcase
	end

	// divider requests: ratio, then the two gains
	always_comb begin
		dv_start = 1'b0;
		dv_num   = it_q.ay;
		dv_den   = 34'(it_q.az);
		s_c      = 34'(p00_q) + 34'(signed'({1'b0, measurement_noise}));
		case (st_q)
			ST_F:   dv_start = !it_q.fault;
			ST_EI:  begin dv_start = s_c != '0; dv_num = p00_q; dv_den = s_c; end
			ST_K0W: begin dv_start = dv_done; dv_num = p10_q; dv_den = s_q; end
			default: dv_start = 1'b0;
		endcase
	end

	// constant divisions from the reciprocal products
	assign d3s = n3_q ? -d3_q : d3_q;
	assign d5u = 33'(prod_q >>> SH5);
	assign d5s = n5_q ? -signed'(d5u[31:0]) : signed'(d5u[31:0]);

	imukf_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (dv_start),
		.num    (dv_num),
		.den    (dv_den),
		.done   (dv_done),
		.quot   (dv_quot)
	);

	assign q_pop  = st_q == ST_IDLE && q_valid;
	assign empty  = !out_v_q;
	assign result = out_q;

	// sequencer, filter state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			out_v_q <= 1'b0;
			ang_q   <= ANG_RST;
			bias_q  <= BIAS_RST;
			caa_q   <= ONE_FX;
			cab_q   <= '0;
			cba_q   <= '0;
			cbb_q   <= ONE_FX;
		end else begin
			prod_q <= ma * mb;
			// result valid: set on load, cleared on pop
			if (st_q == ST_OUT && (!out_v_q || pop))
				out_v_q <= 1'b1;
			else if (pop && out_v_q)
				out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (q_valid) begin
					it_q <= q_item;
					st_q <= ST_A;
				end
				ST_A: st_q <= ST_B;
				ST_B: begin
					ang_q <= sat32(70'(ang_q) + 70'(fxr));
					st_q  <= ST_C;
				end
				ST_C: begin
					t00_q <= sat32(70'(caa_q) - 70'(fxr));
					st_q  <= ST_D;
				end
				ST_D: begin
					t01_q <= sat32(70'(cab_q) - 70'(fxr));
					p10_q <= sat32(70'(cba_q) - 70'(fxr));
					p11_q <= sat32(70'(cbb_q) + 70'(signed'({1'b0, process_noise})));
					st_q  <= ST_E;
				end
				ST_E: st_q <= ST_F;
				ST_F: begin
					p00_q <= sat32(70'(t00_q) - 70'(fxr)
					               + 70'(signed'({1'b0, process_noise})));
					if (it_q.fault) begin
						x_q  <= it_q.xneg ? -(ONE_FX <<< 1) : (ONE_FX <<< 1);
						st_q <= ST_X2;
					end else begin
						st_q <= ST_DW;
					end
				end
				ST_DW: if (dv_done) begin
					x_q  <= dv_quot;
					st_q <= ST_X2;
				end
				ST_X2:  st_q <= ST_X2C;
				ST_X2C: begin
					x2_q <= fxr;
					st_q <= ST_X3;
				end
				ST_X3:  st_q <= ST_X3C;
				ST_X3C: begin
					x3_q <= fxr;
					m3_q <= (fxr[31] ? -33'(fxr) : 33'(fxr)) + 33'd1;
					n3_q <= fxr[31];
					st_q <= ST_X5;
				end
				ST_X5:  st_q <= ST_X5C;
				ST_X5C: begin
					m5_q <= (fxr[31] ? -33'(fxr) : 33'(fxr)) + 33'd2;
					n5_q <= fxr[31];
					st_q <= ST_D5;
				end
				ST_D5: begin
					d3_q <= 32'(prod_q >>> SH3);
					st_q <= ST_ACC;
				end
				ST_ACC: begin
					acc_q <= sat32(70'(x_q) - 70'(d3s) + 70'(d5s));
					st_q  <= ST_EI;
				end
				ST_EI: begin
					e_q <= sat32(70'(acc_q) - 70'(ang_q));
					s_q <= s_c;
					if (s_c == '0) begin
						k0_q <= '0;
						k1_q <= '0;
						st_q <= ST_U0;
					end else begin
						st_q <= ST_K0W;
					end
				end
				ST_K0W: if (dv_done) begin
					k0_q <= dv_quot;
					st_q <= ST_K1W;
				end
				ST_K1W: if (dv_done) begin
					k1_q <= dv_quot;
					st_q <= ST_U0;
				end
				ST_U0: st_q <= ST_U1;
				ST_U1: begin
					ang_q <= sat32(70'(ang_q) + 70'(fxr));
					st_q  <= ST_U2;
				end
				ST_U2: begin
					bias_q <= sat32(70'(bias_q) + 70'(fxr));
					st_q   <= ST_U3;
				end
				ST_U3: begin
					caa_q <= sat32(70'(p00_q) - 70'(fxr));
					st_q  <= ST_U4;
				end
				ST_U4: begin
					cab_q <= sat32(70'(t01_q) - 70'(fxr));
					st_q  <= ST_U5;
				end
				ST_U5: begin
					cba_q <= sat32(70'(p10_q) - 70'(fxr));
					st_q  <= ST_U6;
				end
				ST_U6: begin
					cbb_q <= sat32(70'(p11_q) - 70'(fxr));
					st_q  <= ST_OUT;
				end
				ST_OUT: if (!out_v_q || pop) begin
					out_q.fused_angle   <= ang_q;
					out_q.bias_estimate <= bias_q;
					out_q.tilt_angle    <= acc_q;
					out_q.ratio_fault   <= it_q.fault;
					st_q                <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// divider results only arrive while the sequencer waits for them
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		dv_done |-> (st_q == ST_DW || st_q == ST_K0W || st_q == ST_K1W))
		else $error("divider result outside a wait state");

	// a waiting result is never overwritten
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !pop |=> out_v_q && $stable(out_q))
		else $error("result changed before pop");

	// the queue is only drained from idle
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |=> st_q == ST_A)
		else $error("request taken outside idle");

endmodule

// File: sv/imu_angle_kalman_filter.sv
// Top level of the IMU angle / gyro-bias Kalman filter.
// Depends on imukf_pkg, imukf_front, imukf_back (which uses imukf_div).
//
// Usage:
//  - Input channel: a request (sample) is taken when push is high and full is
//    low. Up to two requests wait in the front queue while one is processed.
//  - Result channel: while empty is low, result holds the oldest estimate;
//    it is taken when pop is high. A stalled receiver holds it, and the back
//    end waits at its last step once the next estimate is ready.
//  - Configuration: cfg_write with cfg_index 0 (dt), 1 (q), 2 (r) writes
//    cfg_data masked to the register width; other indexes are ignored.
//    Write only while no request is in flight.
//  - Sequencing: a saturated ratio skips the ratio division, and a zero gain
//    denominator skips both gain divisions; in general each of the three
//    divisions runs on the shared one-bit-per-cycle divider, and the
//    other steps are the sequencer steps around the shared multiplier.
//    The back end sequencer takes a new request only once the last is done.
//  - Reset (arst_n low) restores angle 0.1, bias 0.001, identity covariance
//    and the default dt, q and r, and empties both queues.
module imu_angle_kalman_filter import imukf_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  in_t              sample,
	output logic             empty,
	input  logic             pop,
	output out_t             result,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);
	localparam logic [TS_W-1:0] TS_RST = TS_W'(((1 << FRAC_BITS) + 100) / 200);
	localparam logic [NZ_W-1:0] PN_RST = NZ_W'(((1 << FRAC_BITS) + 500) / 1000);
	localparam logic [NZ_W-1:0] MN_RST = NZ_W'((1 << FRAC_BITS) * 100);

	logic [TS_W-1:0] ts_q;
	logic [NZ_W-1:0] pn_q, mn_q;
	logic            q_valid, q_pop;
	item_t           q_item;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_q <= TS_RST;
			pn_q <= PN_RST;
			mn_q <= MN_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TIME_STEP:  ts_q <= cfg_data[TS_W-1:0];
				CFG_PROC_NOISE: pn_q <= cfg_data[NZ_W-1:0];
				CFG_MEAS_NOISE: mn_q <= cfg_data[NZ_W-1:0];
				default:        ts_q <= ts_q;
			endcase
		end
	end

	imukf_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	imukf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_valid           (q_valid),
		.q_item            (q_item),
		.q_pop             (q_pop),
		.time_step         (ts_q),
		.process_noise     (pn_q),
		.measurement_noise (mn_q),
		.empty             (empty),
		.pop               (pop),
		.result            (result)
	);

endmodule

// File: tb/imukf_checker.sv
// Checker for the IMU angle Kalman filter: watches the sample, result and
// configuration ports, predicts each estimate and compares. Uses imukf_pkg.
`timescale 1ns / 1ps
module imukf_checker import imukf_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic             full,
	input  in_t              sample,
	input  logic             empty,
	input  logic             pop,
	input  out_t             result,
	input  logic             cfg_write,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	output int               errors,
	output int               pending
);

	localparam longint ONE  = 64'sd65536;
	localparam longint HALF = 64'sd32768;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;

	// model registers and filter state
	longint dt_q, q_noise, r_noise;
	longint ang, bias, p_aa, p_ab, p_ba, p_bb;
	out_t   est_q[$];
	int     err_n;

	function automatic longint clamp(input longint v);
		if (v > SMAX) return SMAX;
		if (v < SMIN) return SMIN;
		return v;
	endfunction

	// fixed-point product, round half up
	function automatic longint fmul(input longint a, input longint b);
		return clamp((a * b + HALF) >>> 16);
	endfunction

	function automatic longint unsigned absval(input longint v);
		return (v < 0) ? longint'(0) - v : v;
	endfunction

	// rounded quotient n * 2^sc / d, ties away from zero
	function automatic longint rdiv(input longint n, input longint d, input int sc);
		longint unsigned un, ud, qq;
		longint rr;
		un = absval(n) << sc;
		ud = absval(d);
		qq = (un + ud / 2) / ud;
		if (qq > 64'd2147483648) qq = 64'd2147483648;
		rr = longint'(qq);
		if ((n < 0) != (d < 0)) rr = -rr;
		return clamp(rr);
	endfunction

	// one filter step on a sample, updating the model state
	function automatic out_t next_estimate(input in_t s);
		longint ay, az, g, x, x2, x3, x5, acc;
		longint t00, t01, p00, p01, p10, p11, sden, k0, k1, e;
		logic   flt;
		out_t   o;
		ay = s.accel_lateral;
		az = s.accel_vertical;
		g  = s.gyro_rate;
		flt = 1'b0;
		ang = clamp(ang + fmul(dt_q, g - bias));
		t00 = clamp(p_aa - fmul(dt_q, p_ba));
		t01 = clamp(p_ab - fmul(dt_q, p_bb));
		p00 = clamp(t00 - fmul(dt_q, t01) + q_noise);
		p01 = t01;
		p10 = clamp(p_ba - fmul(dt_q, p_bb));
		p11 = clamp(p_bb + q_noise);
		// ratio with zero-divisor and beyond-two limiting
		if (az == 0) begin
			flt = 1'b1;
			x = (ay < 0) ? -2 * ONE : 2 * ONE;
		end else if (absval(ay) > 2 * absval(az)) begin
			flt = 1'b1;
			x = ((ay < 0) != (az < 0)) ? -2 * ONE : 2 * ONE;
		end else begin
			x = rdiv(ay, az, 16);
		end
		x2 = fmul(x, x);
		x3 = fmul(x2, x);
		x5 = fmul(x3, x2);
		acc = clamp(x - rdiv(x3, 3, 0) + rdiv(x5, 5, 0));
		// gains, zero when the innovation denominator vanishes
		sden = p00 + r_noise;
		if (sden == 0) begin
			k0 = 0;
			k1 = 0;
		end else begin
			k0 = rdiv(p00, sden, 16);
			k1 = rdiv(p10, sden, 16);
		end
		e = clamp(acc - ang);
		ang  = clamp(ang + fmul(k0, e));
		bias = clamp(bias + fmul(k1, e));
		p_aa = clamp(p00 - fmul(k0, p00));
		p_ab = clamp(p01 - fmul(k0, p01));
		p_ba = clamp(p10 - fmul(k1, p00));
		p_bb = clamp(p11 - fmul(k1, p01));
		o.fused_angle   = ang[31:0];
		o.bias_estimate = bias[31:0];
		o.tilt_angle    = acc[31:0];
		o.ratio_fault   = flt;
		return o;
	endfunction

	function automatic void flag(input string msg);
		err_n++;
		if (err_n <= 10) $display("MISMATCH %s", msg);
	endfunction

	// watch the three channels
	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			dt_q = 328; q_noise = 66; r_noise = 6553600;
			ang = 6554; bias = 66;
			p_aa = ONE; p_ab = 0; p_ba = 0; p_bb = ONE;
			est_q.delete();
			err_n = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					CFG_TIME_STEP:  dt_q    = cfg_data[TS_W-1:0];
					CFG_PROC_NOISE: q_noise = cfg_data[NZ_W-1:0];
					CFG_MEAS_NOISE: r_noise = cfg_data[NZ_W-1:0];
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (est_q.size() == 0) begin
					flag("estimate with no request waiting");
				end else begin
					want = est_q.pop_front();
					if (result.fused_angle !== want.fused_angle)
						flag($sformatf("fused_angle exp %0d got %0d",
							want.fused_angle, result.fused_angle));
					if (result.bias_estimate !== want.bias_estimate)
						flag($sformatf("bias_estimate exp %0d got %0d",
							want.bias_estimate, result.bias_estimate));
					if (result.tilt_angle !== want.tilt_angle)
						flag($sformatf("tilt_angle exp %0d got %0d",
							want.tilt_angle, result.tilt_angle));
					if (result.ratio_fault !== want.ratio_fault)
						flag($sformatf("ratio_fault exp %0b got %0b",
							want.ratio_fault, result.ratio_fault));
				end
			end
			if (push && !full) est_q.push_back(next_estimate(sample));
			errors  <= err_n;
			pending <= est_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
// Testbench top for imu_angle_kalman_filter: clock, reset, sample and
// configuration stimulus, verdict. Uses imukf_pkg and imukf_checker.
`timescale 1ns / 1ps
module tb_top;
	import imukf_pkg::*;

	localparam int STALL_LIMIT = 20000;
	localparam int N_RAND      = 108;

	logic             clk;
	logic             arst_n;
	logic             push;
	logic             full;
	in_t              sample;
	logic             empty;
	logic             pop;
	out_t             result;
	logic             cfg_write;
	logic [1:0]       cfg_index;
	logic [CFG_W-1:0] cfg_data;
	int               errors;
	int               pending;
	int               send_idle_pct;
	int               pop_stall_pct;
	int               quiet_cnt;

	imu_angle_kalman_filter u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .result(result), .cfg_write(cfg_write),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	imukf_checker u_chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .sample(sample),
		.empty(empty), .pop(pop), .result(result), .cfg_write(cfg_write),
		.cfg_index(cfg_index), .cfg_data(cfg_data), .errors(errors),
		.pending(pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver with random stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) pop <= 1'b0;
		else pop <= ($urandom_range(99) >= pop_stall_pct);
	end

	// watchdog on cycles with no request accepted on either side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cnt <= 0;
		end else begin
			if ((push && !full) || (pop && !empty)) quiet_cnt <= 0;
			else quiet_cnt <= quiet_cnt + 1;
			if (quiet_cnt > STALL_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

	// send one sample; push stays high across back-to-back requests
	task automatic send(input logic [31:0] ay, input logic [31:0] az,
			input logic [31:0] g);
		if ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct) @(posedge clk);
		end
		push <= 1'b1;
		sample.accel_lateral  <= ay;
		sample.accel_vertical <= az;
		sample.gyro_rate      <= g;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// stop sending and let every estimate come out
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	task automatic cfg_set(input logic [1:0] idx, input logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
	endtask

	// mostly plausible tilt samples, some full-range noise and limit cases
	task automatic send_random();
		int m;
		logic [31:0] ay, az, g;
		m = $urandom_range(99);
		if (m < 20) begin
			ay = $urandom; az = $urandom; g = $urandom;
		end else if (m < 30) begin
			ay = $urandom;
			az = ($urandom_range(1) == 0) ? 32'd0 : ($urandom >>> $urandom_range(31));
			g = $urandom_range(2097152) - 1048576;
		end else begin
			ay = $urandom_range(131072) - 65536;
			az = $urandom_range(1) ? 65536 - $urandom_range(8192)
				: -65536 + $urandom_range(8192);
			g = $urandom_range(262144) - 131072;
		end
		send(ay, az, g);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		sample = '0;
		cfg_write = 1'b0;
		cfg_index = CFG_TIME_STEP;
		cfg_data = '0;
		send_idle_pct = 0;
		pop_stall_pct = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero, zero divisor both signs, ratio at and past two
		send(32'd0, 32'd0, 32'd0);
		send(32'd1, 32'd0, 32'd0);
		send(-32'd1, 32'd0, 32'd100);
		send(32'd131072, 32'd65536, 32'd0);
		send(32'd131073, 32'd65536, 32'd0);
		send(-32'd131072, 32'd65536, 32'd0);
		send(32'd131072, -32'd65536, 32'd0);
		send(-32'd131073, -32'd65536, 32'd0);
		send(32'd65536, 32'd65536, 32'd0);
		send(-32'd3, -32'd7, 32'd5);
		send(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
		send(32'h80000000, 32'h80000000, 32'h80000000);
		send(32'h80000000, 32'd1, 32'h7FFFFFFF);
		send(32'h80000000, -32'd1, 32'h80000000);
		send(32'hFFFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF);
		send(32'd40000, 32'd60000, -32'd65536);
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				1: begin
					cfg_set(CFG_TIME_STEP, 31'd65536);
					cfg_set(CFG_PROC_NOISE, 31'd0);
					cfg_set(CFG_MEAS_NOISE, 31'd1);
				end
				2: begin
					cfg_set(CFG_TIME_STEP, 31'd1);
					cfg_set(CFG_PROC_NOISE, 31'h7FFFFFFF);
					cfg_set(CFG_MEAS_NOISE, 31'h7FFFFFFF);
				end
				3: begin
					// upper bits beyond the dt width are dropped
					cfg_set(CFG_TIME_STEP, 31'h7FFE0000 | 31'd200);
					cfg_set(CFG_PROC_NOISE, 31'd655);
					cfg_set(CFG_MEAS_NOISE, 31'd65536);
					cfg_set(2'd3, 31'd12345);
				end
				4: begin
					cfg_set(CFG_TIME_STEP, 31'd328);
					cfg_set(CFG_PROC_NOISE, 31'd66);
					cfg_set(CFG_MEAS_NOISE, 31'd6553600);
				end
				5: begin
					cfg_set(CFG_TIME_STEP, 31'($urandom_range(65536, 1)));
					cfg_set(CFG_PROC_NOISE, 31'($urandom_range(100000)));
					cfg_set(CFG_MEAS_NOISE, 31'($urandom_range(20000000, 1)));
				end
				default: ;
			endcase
			cfg_write <= 1'b0;
			case (ph % 4)
				0: begin send_idle_pct = 0;  pop_stall_pct = 0;  end
				1: begin send_idle_pct = 85; pop_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  pop_stall_pct = 85; end
				default: begin send_idle_pct = 38; pop_stall_pct = 38; end
			endcase
			for (int i = 0; i < N_RAND; i++) send_random();
			drain();
		end

		if (errors == 0 && pending == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
